### rtl/core/csvt_pkg.sv
// ----------------------------------------------------------------------------
// csvt_pkg
// Shared types and constants for the CSV record tokenizer.
// ----------------------------------------------------------------------------
package csvt_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned FieldW  = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 8;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_HEADER_SKIP = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_FIELDS_PER_REC = 2'd1;

  localparam logic [ByteW-1:0]  HEADER_SKIP_RST = 8'd98;
  localparam logic [FieldW-1:0] FIELDS_PER_REC_RST = 4'd9;

  localparam logic [ByteW-1:0] CH_COMMA   = 8'h2C;
  localparam logic [ByteW-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [ByteW-1:0] CH_QUOTE   = 8'h22;

  typedef struct packed {
    logic [ByteW-1:0]  out_byte;
    logic              has_byte;
    logic [FieldW-1:0] field_number;
    logic              field_done;
    logic              record_done;
  } result_t;

endpackage

### rtl/core/csv_record_tokenizer.sv
// ----------------------------------------------------------------------------
// csv_record_tokenizer
// Byte-serial CSV tokenizer with quoted fields and per-record field count.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carries one text byte per item. out_valid/out_ready
//   carries at most one result item per input byte: a content byte
//   (out_has_byte) or an end-of-field marker (out_field_done, with
//   out_record_done on the last field of a record). Bytes that are skipped
//   or dropped give no result.
//   cfg_valid/cfg_ready writes register cfg_index (0 header skip length,
//   1 fields per record); cfg_ready is always high. Write only when idle.
//   A byte is accepted into the input register; the result register loads
//   from it once it has room (the byte waits in the input register until
//   then). Throughput: one byte per cycle while the receiver does not
//   stall, set by the phase update between the two registers.
//   When the receiver stalls, the result register holds its item and the
//   input register still takes one more byte; in_ready then drops until
//   the result is taken.
//   Reset clears the phase, field and skip counters and loads the register
//   defaults (98 header bytes, 9 fields per record).
// ----------------------------------------------------------------------------
module csv_record_tokenizer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [csvt_pkg::ByteW-1:0]    in_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [csvt_pkg::ByteW-1:0]    out_byte,
  output logic                          out_has_byte,
  output logic [csvt_pkg::FieldW-1:0]   out_field_number,
  output logic                          out_field_done,
  output logic                          out_record_done,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [csvt_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [csvt_pkg::CfgDatW-1:0]  cfg_data
);
  import csvt_pkg::*;

  logic             in_vld_r;
  logic [ByteW-1:0] in_byte_r;
  logic             step;
  logic             res_valid;
  result_t          res;
  result_t          res_q;

  // the staged byte moves on once the result register has room
  assign step      = in_vld_r && (!out_valid || out_ready);
  assign in_ready  = !in_vld_r || step;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte;
    end
  end

  csvt_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .byte_in   (in_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  csvt_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && res_valid),
    .res_in    (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_out   (res_q)
  );

  assign out_byte         = res_q.out_byte;
  assign out_has_byte     = res_q.has_byte;
  assign out_field_number = res_q.field_number;
  assign out_field_done   = res_q.field_done;
  assign out_record_done  = res_q.record_done;

endmodule

### rtl/core/csvt_parser.sv
// ----------------------------------------------------------------------------
// csvt_parser
// Header skip, quote-aware phase machine and field counter; one byte a step.
// ----------------------------------------------------------------------------
module csvt_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [csvt_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [csvt_pkg::CfgDatW-1:0]  cfg_data,
  input  logic                          step,
  input  logic [csvt_pkg::ByteW-1:0]    byte_in,
  output logic                          res_valid,
  output csvt_pkg::result_t             res
);
  import csvt_pkg::*;

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_PLAIN  = 2'd1;
  localparam logic [1:0] PH_QUOTED = 2'd2;
  localparam logic [1:0] PH_AFTERQ = 2'd3;

  logic [ByteW-1:0]  header_skip_r;
  logic [FieldW-1:0] fields_per_rec_r;
  logic [1:0]        phase_r, phase_nxt;
  logic [FieldW-1:0] field_cnt_r, field_cnt_nxt;
  logic [ByteW-1:0]  skip_cnt_r, skip_cnt_nxt;

  logic              emit;
  logic              end_fld;
  logic [FieldW:0]   idx_inc;
  logic              last_fld;
  logic              is_comma, is_nl, is_quote;

  assign is_comma = (byte_in == CH_COMMA);
  assign is_nl    = (byte_in == CH_NEWLINE);
  assign is_quote = (byte_in == CH_QUOTE);

  // a record size of zero still ends every field as a record
  assign idx_inc  = {1'b0, field_cnt_r} + {{FieldW{1'b0}}, 1'b1};
  assign last_fld = (idx_inc >= {1'b0, fields_per_rec_r});

  always_comb begin
    emit         = 1'b0;
    end_fld      = 1'b0;
    phase_nxt    = phase_r;
    skip_cnt_nxt = skip_cnt_r;
    if (skip_cnt_r < header_skip_r) begin
      skip_cnt_nxt = skip_cnt_r + 8'd1;
    end else begin
      case (phase_r)
        PH_START: begin
          if (is_quote) begin
            phase_nxt = PH_QUOTED;
          end else if (is_comma) begin
            end_fld = 1'b1;
          end else if (!is_nl) begin
            emit      = 1'b1;
            phase_nxt = PH_PLAIN;
          end
        end
        PH_PLAIN: begin
          if (is_comma || is_nl) begin
            end_fld = 1'b1;
          end else if (!is_quote) begin
            emit = 1'b1;
          end
        end
        PH_QUOTED: begin
          if (is_quote) begin
            phase_nxt = PH_AFTERQ;
          end else begin
            emit = 1'b1;
          end
        end
        PH_AFTERQ: begin
          // doubled quote gives a literal; anything but a delimiter is dropped
          if (is_quote) begin
            emit      = 1'b1;
            phase_nxt = PH_QUOTED;
          end else if (is_comma || is_nl) begin
            end_fld = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_START;
        end
      endcase
      if (end_fld) begin
        phase_nxt = PH_START;
      end
    end
  end

  always_comb begin
    field_cnt_nxt = field_cnt_r;
    if (end_fld) begin
      field_cnt_nxt = last_fld ? '0 : idx_inc[FieldW-1:0];
    end
  end

  assign res_valid        = emit || end_fld;
  assign res.out_byte     = emit ? byte_in : '0;
  assign res.has_byte     = emit;
  assign res.field_number = field_cnt_r;
  assign res.field_done   = end_fld;
  assign res.record_done  = end_fld && last_fld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      field_cnt_r <= '0;
      skip_cnt_r  <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      field_cnt_r <= field_cnt_nxt;
      skip_cnt_r  <= skip_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_skip_r    <= HEADER_SKIP_RST;
      fields_per_rec_r <= FIELDS_PER_REC_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEADER_SKIP:    header_skip_r    <= cfg_data;
        REG_FIELDS_PER_REC: fields_per_rec_r <= cfg_data[FieldW-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/csvt_out_reg.sv
// ----------------------------------------------------------------------------
// csvt_out_reg
// Result register holding one item until the receiver takes it.
// ----------------------------------------------------------------------------
module csvt_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  csvt_pkg::result_t res_in,
  input  logic              out_ready,
  output logic              out_valid,
  output csvt_pkg::result_t res_out
);
  import csvt_pkg::*;

  logic    valid_r;
  result_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

### rtl/core/csvt_checker.sv
// ----------------------------------------------------------------------------
// csvt_checker
// Port-level checks on the tokenizer's result channel.
// ----------------------------------------------------------------------------
module csvt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [csvt_pkg::ByteW-1:0]    out_byte,
  input logic                          out_has_byte,
  input logic [csvt_pkg::FieldW-1:0]   out_field_number,
  input logic                          out_field_done,
  input logic                          out_record_done
);
  import csvt_pkg::*;

  // a stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte)
      && $stable(out_field_number) && $stable(out_field_done))
    else $error("result item changed while stalled");

  // an item is either a content byte or a field end, never both or neither
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_has_byte != out_field_done))
    else $error("result item kind is ambiguous");

  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_field_done |-> (out_byte == '0) && !out_has_byte)
    else $error("field end carries a content byte");

  a_record: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_done |-> out_field_done)
    else $error("record end without field end");

  // the counter wraps before reaching the largest record size
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_field_number != {FieldW{1'b1}}))
    else $error("field number out of range");

endmodule

bind csv_record_tokenizer csvt_checker u_csvt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_byte         (out_byte),
  .out_has_byte     (out_has_byte),
  .out_field_number (out_field_number),
  .out_field_done   (out_field_done),
  .out_record_done  (out_record_done)
);

### sim/csv_token_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_token_checker
// Watches the byte, result and register channels of the CSV tokenizer. It
// keeps its own copy of the parser state and register values, works out the
// token each accepted byte should give, and compares every result item with
// the oldest token still owed.
// ----------------------------------------------------------------------------
module csv_token_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [csvt_pkg::ByteW-1:0]    in_byte,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [csvt_pkg::ByteW-1:0]    out_byte,
  input  logic                          out_has_byte,
  input  logic [csvt_pkg::FieldW-1:0]   out_field_number,
  input  logic                          out_field_done,
  input  logic                          out_record_done,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [csvt_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [csvt_pkg::CfgDatW-1:0]  cfg_data,
  output int                            mismatches,
  output int                            outstanding,
  output int                            results_checked,
  output int                            records_closed
);
  import csvt_pkg::*;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_PLAIN  = 2'd1,
    PH_QUOTED = 2'd2,
    PH_AFTERQ = 2'd3
  } parse_phase_e;

  logic [ByteW-1:0]  skip_len;
  logic [FieldW-1:0] rec_len;
  parse_phase_e      phase;
  logic [FieldW-1:0] field_idx;
  logic [ByteW-1:0]  skipped;
  result_t           owed_tokens[$];

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= 40)
      $display("[%0t] MISMATCH %s", $time, what);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report($sformatf("result %0d: %s is %0h, expected %0h",
                       results_checked, name, got, want));
  endtask

  // Advances the parser by one byte; returns 1 when a token is produced.
  function automatic bit tokenize_byte(input logic [ByteW-1:0] c, output result_t tok);
    bit emit;
    bit close;
    bit rec_end;
    emit  = 1'b0;
    close = 1'b0;
    tok   = '0;
    if (skipped < skip_len) begin
      skipped++;
      return 1'b0;
    end
    case (phase)
      PH_START: begin
        if (c == CH_QUOTE) phase = PH_QUOTED;
        else if (c == CH_COMMA) close = 1'b1;
        else if (c != CH_NEWLINE) begin
          phase = PH_PLAIN;
          emit  = 1'b1;
        end
      end
      PH_PLAIN: begin
        if (c == CH_COMMA || c == CH_NEWLINE) close = 1'b1;
        else if (c != CH_QUOTE) emit = 1'b1;
      end
      PH_QUOTED: begin
        if (c == CH_QUOTE) phase = PH_AFTERQ;
        else emit = 1'b1;
      end
      default: begin
        // after a quote: doubled quote is literal, junk is dropped
        if (c == CH_QUOTE) begin
          phase = PH_QUOTED;
          emit  = 1'b1;
        end else if (c == CH_COMMA || c == CH_NEWLINE) close = 1'b1;
      end
    endcase
    if (emit) begin
      tok.out_byte     = c;
      tok.has_byte     = 1'b1;
      tok.field_number = field_idx;
    end
    if (close) begin
      // a record size of zero behaves as one
      rec_end          = ({1'b0, field_idx} + 5'd1) >= {1'b0, rec_len};
      tok.field_number = field_idx;
      tok.field_done   = 1'b1;
      tok.record_done  = rec_end;
      field_idx        = rec_end ? '0 : field_idx + 1'b1;
      phase            = PH_START;
    end
    return emit | close;
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      skip_len        = HEADER_SKIP_RST;
      rec_len         = FIELDS_PER_REC_RST;
      phase           = PH_START;
      field_idx       = '0;
      skipped         = '0;
      mismatches      = 0;
      results_checked = 0;
      records_closed  = 0;
      owed_tokens.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_HEADER_SKIP) skip_len = cfg_data;
        else if (cfg_index == REG_FIELDS_PER_REC) rec_len = cfg_data[FieldW-1:0];
      end
      if (in_valid && in_ready) begin
        if (tokenize_byte(in_byte, want)) owed_tokens.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = {out_byte, out_has_byte, out_field_number, out_field_done, out_record_done};
        if (owed_tokens.size() == 0) begin
          report($sformatf("result %0d arrived with nothing owed", results_checked));
        end else begin
          want = owed_tokens.pop_front();
          check_field("out_byte", int'(got.out_byte), int'(want.out_byte));
          check_field("has_byte", int'(got.has_byte), int'(want.has_byte));
          check_field("field_number", int'(got.field_number), int'(want.field_number));
          check_field("field_done", int'(got.field_done), int'(want.field_done));
          check_field("record_done", int'(got.record_done), int'(want.record_done));
          if (want.record_done) records_closed++;
        end
        results_checked++;
      end
    end
    outstanding <= owed_tokens.size();
  end

endmodule

### sim/tb_csv_record_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_csv_record_tokenizer
// Feeds the tokenizer header bytes, a hand-made stretch of CSV text and then
// random records (plain, quoted, empty and malformed fields) under a series
// of register settings, with bursty input and a stalling receiver. Results
// are checked by csv_token_checker.
// ----------------------------------------------------------------------------
module tb_csv_record_tokenizer;
  import csvt_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN       = 4;
  localparam int NUM_PHASES  = 9;

  // indexes that map to no register
  localparam logic [CfgIdxW-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SPARE_3 = 2'd3;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_e;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [ByteW-1:0]    in_byte;
  logic                out_valid;
  logic                out_ready;
  logic [ByteW-1:0]    out_byte;
  logic                out_has_byte;
  logic [FieldW-1:0]   out_field_number;
  logic                out_field_done;
  logic                out_record_done;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDatW-1:0]  cfg_data;

  int mismatches;
  int outstanding;
  int results_checked;
  int records_closed;

  int bytes_sent = 0;
  int burst_left = 0;
  int cycle_cnt  = 0;
  int stall_left = 0;
  int tick       = 0;
  rx_mode_e stall_mode = RX_OPEN;

  csv_record_tokenizer DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_has_byte     (out_has_byte),
    .out_field_number (out_field_number),
    .out_field_done   (out_field_done),
    .out_record_done  (out_record_done),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  csv_token_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_has_byte     (out_has_byte),
    .out_field_number (out_field_number),
    .out_field_done   (out_field_done),
    .out_record_done  (out_record_done),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .results_checked  (results_checked),
    .records_closed   (records_closed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results owed", cycle_cnt, outstanding);
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver back-pressure, with the pattern picked anew at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = rx_mode_e'($urandom_range(0, 3));
        stall_left = $urandom_range(20, 300);
      end
      stall_left--;
      tick++;
      case (stall_mode)
        RX_OPEN:     out_ready <= 1'b1;
        RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
        RX_PERIODIC: out_ready <= (tick % 7) < 2;
        default:     out_ready <= $urandom_range(0, 9) != 0;
      endcase
    end
  end

  task automatic push_byte(input logic [ByteW-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 250)
                                                : $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // hold input until every owed result is out, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic reprogram(input logic [7:0] hdr, input logic [7:0] rec, input bit poke_spare);
    settle();
    if (poke_spare) begin
      set_reg(REG_SPARE_2, 8'hFF);
      set_reg(REG_SPARE_3, 8'($urandom_range(0, 255)));
    end
    set_reg(REG_HEADER_SKIP, hdr);
    set_reg(REG_FIELDS_PER_REC, rec);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_COMMA || c == CH_NEWLINE || c == CH_QUOTE);
    return c;
  endfunction

  function automatic logic [7:0] quoted_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
    return c;
  endfunction

  task automatic send_field(input bit ends_record);
    int kind;
    int len;
    kind = $urandom_range(0, 9);
    len  = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 5);
    if (kind < 5) begin
      for (int i = 0; i < len; i++) begin
        // occasional raw noise, stray quotes included
        if ($urandom_range(0, 11) == 0) push_byte(8'($urandom_range(0, 255)));
        else push_byte(plain_char());
      end
    end else if (kind < 9) begin
      push_byte(CH_QUOTE);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          push_byte(CH_QUOTE);
          push_byte(CH_QUOTE);
        end else begin
          push_byte(quoted_char());
        end
      end
      push_byte(CH_QUOTE);
      if ($urandom_range(0, 9) == 0) push_byte(plain_char());
    end
    push_byte(ends_record ? CH_NEWLINE : CH_COMMA);
  endtask

  task automatic send_record(input int nfields);
    if ($urandom_range(0, 9) == 0) push_byte(CH_NEWLINE);
    for (int f = 0; f < nfields; f++) send_field(f == nfields - 1);
  endtask

  initial begin
    logic [7:0] probe_seq[24];
    logic [7:0] hdr_set[NUM_PHASES];
    logic [7:0] rec_set[NUM_PHASES];
    int         budget[NUM_PHASES];
    int         stop_at;
    int         rec_fields;

    in_valid  = 1'b0;
    in_byte   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rst_n     = 1'b0;

    // blank line, 00/FF with a stray quote, empty field, quoted field with
    // embedded comma/newline, doubled quote and junk after the close, empty
    // quoted field, plain field ended by newline, then empties to field 8
    probe_seq = '{CH_NEWLINE, 8'h00, 8'hFF, CH_QUOTE, CH_COMMA,
                  CH_COMMA,
                  CH_QUOTE, CH_COMMA, CH_NEWLINE, CH_QUOTE, CH_QUOTE, 8'h78,
                  CH_QUOTE, 8'h7A, CH_NEWLINE,
                  CH_QUOTE, CH_QUOTE, CH_COMMA,
                  8'h62, CH_NEWLINE,
                  CH_COMMA, CH_COMMA, CH_COMMA, CH_COMMA};

    // phase 3 stops mid-header, phase 4 lowers the skip length and the
    // record size, phase 5 raises the skip length again
    hdr_set = '{8'd100, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0};
    rec_set = '{8'h13, 8'h00, 8'h0F, 8'h0E, 8'h02, 8'hF9, 8'h00, 8'h01, 8'hFF};
    budget  = '{110, 90, 150, 60, 90, 190, 150, 90, 110};
    hdr_set[6] = 8'($urandom_range(0, 255));
    rec_set[6] = 8'($urandom_range(1, 15));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: 98 header bytes, then a record of nine fields
    repeat (int'(HEADER_SKIP_RST)) push_byte(8'($urandom_range(0, 255)));
    foreach (probe_seq[i]) push_byte(probe_seq[i]);

    for (int k = 0; k < NUM_PHASES; k++) begin
      reprogram(hdr_set[k], rec_set[k], k == 0 || k == 7);
      if (k == 3) begin
        repeat (budget[k]) push_byte(8'($urandom_range(0, 255)));
      end else begin
        stop_at = bytes_sent + budget[k];
        while (bytes_sent < stop_at) begin
          rec_fields = (rec_set[k][3:0] == 4'd0) ? 1 : int'(rec_set[k][3:0]);
          if ($urandom_range(0, 4) == 0) rec_fields = $urandom_range(1, 15);
          send_record(rec_fields);
        end
        // leave a record half done so the next setting starts mid-record
        repeat ($urandom_range(0, 3)) send_field(1'b0);
      end
    end
    settle();

    $display("Sent %0d text bytes under %0d register settings, skip lengths 0 to 255",
             bytes_sent, NUM_PHASES + 1);
    $display("Checked %0d results, %0d of them closing a record of 1 to 15 fields",
             results_checked, records_closed);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
